// ===== rtl/core/bridge_adc_reader_with_tare_assert.svh =====
// Assertion macros used by the bridge reader top level
`ifndef BRIDGE_ADC_READER_WITH_TARE_ASSERT_SVH
`define BRIDGE_ADC_READER_WITH_TARE_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define BADC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bridge reader check failed");

// Check a condition in the cycle after its trigger
`define BADC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bridge reader check failed");

`endif

// ===== rtl/core/badc_pkg.sv =====
`default_nettype none

package badc_pkg;

    localparam int DATA_BITS    = 24;
    localparam int EXTRA_PULSES = 3;
    localparam int MAX_SAMPLES  = 255;

    localparam int CNT_W   = 8;
    localparam int GAP_W   = 16;
    localparam int SUM_W   = 32;
    localparam int PULSE_W = 5;
    localparam int VAL_W   = DATA_BITS + 1;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(10);
    localparam logic [GAP_W-1:0] GAP_TICKS_RST    = GAP_W'(5000);

    // Register select bit of the configuration address
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_GAP_TICKS    = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_RAW  = 2'd1,
        CMD_ZERO = 2'd2,
        CMD_CAL  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_RISE  = 3'd2,
        PH_FALL  = 3'd3,
        PH_XRISE = 3'd4,
        PH_XFALL = 3'd5,
        PH_GAP   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DIV  = 2'd1,
        CS_FIN  = 2'd2
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } ctl_sts_t;

    // Number of conversions per averaged measurement
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n == '0)
        begin
            n = CNT_W'(1);
        end
        if (n > CNT_W'(MAX_SAMPLES))
        begin
            n = CNT_W'(MAX_SAMPLES);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bridge_adc_reader_with_tare.sv =====
// Output: a tick's result is registered and appears in the cycle after acceptance; for the
// tick that ends an averaged measurement it appears after the divider and the finish state.
// Throughput: one tick per cycle unless the output stalls; the tick that ends an averaged
// measurement holds the input for start, 32 shift-subtract divider steps, hand-over and load.
// Reset (rst_n low, asynchronous): sequence idle, offsets zero, output empty,
// sample_count 10, gap_ticks 5000.
`default_nettype none

`include "bridge_adc_reader_with_tare_assert.svh"

module bridge_adc_reader_with_tare (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Tick requests
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            dout_a,
    input  wire logic                            dout_b,
    input  wire logic [1:0]                      command,
    input  wire logic                            channel,
    // Results
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 sck_a,
    output logic                                 sck_b,
    output logic                                 result_valid,
    output logic signed [badc_pkg::VAL_W-1:0]    result_value,
    output logic                                 busy_res,
    output logic [badc_pkg::DATA_BITS-1:0]       offset_a_out,
    output logic [badc_pkg::DATA_BITS-1:0]       offset_b_out
);
    import badc_pkg::*;

    logic [CNT_W-1:0] sample_count_reg;
    logic [GAP_W-1:0] gap_ticks_reg;
    logic             cfg_wr;
    ctl_cmd_t         ctl_cmd;
    ctl_sts_t         ctl_sts;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            gap_ticks_reg    <= GAP_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SAMPLE_COUNT)
            begin
                sample_count_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                gap_ticks_reg <= pwdata[GAP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GAP_TICKS) ? 32'(gap_ticks_reg) : 32'(sample_count_reg);

    badc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    badc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .sts          (ctl_sts),
        .sample_count (sample_count_reg),
        .gap_ticks    (gap_ticks_reg),
        .dout_a       (dout_a),
        .dout_b       (dout_b),
        .command      (command),
        .channel      (channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck_a        (sck_a),
        .sck_b        (sck_b),
        .result_valid (result_valid),
        .result_value (result_value),
        .busy_res     (busy_res),
        .offset_a_out (offset_a_out),
        .offset_b_out (offset_b_out)
    );

    // A finished value always closes its command
    `BADC_ASSERT_NOW(a_result_idle, out_valid && result_valid, !busy_res)
    // Only the active channel's clock may toggle
    `BADC_ASSERT_NOW(a_one_clock, out_valid, !(sck_a && sck_b))
    // Hold off new ticks while the average is being divided
    `BADC_ASSERT_NEXT(a_div_holds, ctl_cmd.accept && ctl_sts.need_div, in_stall && ctl_sts.div_busy)

endmodule

`default_nettype wire

// ===== rtl/core/badc_div.sv =====
`default_nettype none

module badc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [badc_pkg::SUM_W-1:0]  dividend,
    input  wire logic [badc_pkg::CNT_W-1:0]  divisor,
    output logic                             busy,
    output logic [badc_pkg::SUM_W-1:0]       quotient
);
    import badc_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W:0]      trial;

    // One restoring step per cycle, dividend shifts out as quotient shifts in
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/badc_ctrl.sv =====
`default_nettype none

module badc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire badc_pkg::ctl_sts_t    sts,
    output badc_pkg::ctl_cmd_t         cmd
);
    import badc_pkg::*;

    ctl_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid && sts.out_free && sts.need_div)
                begin
                    state_next = CS_DIV;
                end
            end
            CS_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = CS_FIN;
                end
            end
            CS_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        in_stall      = 1'b1;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_stall      = !sts.out_free;
                cmd.accept    = in_valid && sts.out_free;
                cmd.div_start = in_valid && sts.out_free && sts.need_div;
            end
            CS_FIN:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/badc_dp.sv =====
`default_nettype none

module badc_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire badc_pkg::ctl_cmd_t              cmd,
    output badc_pkg::ctl_sts_t                   sts,
    input  wire logic [badc_pkg::CNT_W-1:0]      sample_count,
    input  wire logic [badc_pkg::GAP_W-1:0]      gap_ticks,
    input  wire logic                            dout_a,
    input  wire logic                            dout_b,
    input  wire logic [1:0]                      command,
    input  wire logic                            channel,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 sck_a,
    output logic                                 sck_b,
    output logic                                 result_valid,
    output logic signed [badc_pkg::VAL_W-1:0]    result_value,
    output logic                                 busy_res,
    output logic [badc_pkg::DATA_BITS-1:0]       offset_a_out,
    output logic [badc_pkg::DATA_BITS-1:0]       offset_b_out
);
    import badc_pkg::*;

    phase_t                phase_reg, phase_next;
    cmd_t                  acmd_reg, acmd_next;
    logic                  ach_reg, ach_next;
    logic [PULSE_W-1:0]    pulse_reg, pulse_next;
    logic [DATA_BITS-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]      done_reg, done_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [GAP_W-1:0]      gap_reg, gap_next;
    logic [DATA_BITS-1:0]  off_a_reg, off_a_next;
    logic [DATA_BITS-1:0]  off_b_reg, off_b_next;

    logic                  ov_reg, ov_next;
    logic                  sck_a_reg, sck_b_reg, rv_reg, busy_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [DATA_BITS-1:0]  oa_reg, ob_reg;

    logic                  dout;
    logic [PULSE_W-1:0]    pulse_inc;
    logic [CNT_W-1:0]      done_inc;
    logic [SUM_W-1:0]      sum_add;
    logic [CNT_W-1:0]      n_eff;
    logic                  need_div;
    logic                  load;
    logic                  sck;
    logic                  valid;
    logic [VAL_W-1:0]      value;
    logic [DATA_BITS-1:0]  avg;
    logic [DATA_BITS-1:0]  off_sel;
    logic                  div_busy;
    logic [SUM_W-1:0]      quotient;

    assign dout      = ach_reg ? dout_b : dout_a;
    assign pulse_inc = pulse_reg + PULSE_W'(1);
    assign done_inc  = done_reg + CNT_W'(1);
    assign sum_add   = sum_reg + SUM_W'(shift_reg);
    assign n_eff     = eff_count(sample_count);
    assign avg       = quotient[DATA_BITS-1:0];
    assign off_sel   = ach_reg ? off_b_reg : off_a_reg;

    // The last conversion of an averaged measurement needs the divider
    assign need_div = (phase_reg == PH_XFALL)
                   && (pulse_inc >= PULSE_W'(EXTRA_PULSES))
                   && (acmd_reg != CMD_RAW)
                   && (done_inc >= n_eff);

    badc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_add),
        .divisor  (n_eff),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Advance the converter sequence by one tick, or apply the finished average
    always_comb
    begin
        phase_next = phase_reg;
        acmd_next  = acmd_reg;
        ach_next   = ach_reg;
        pulse_next = pulse_reg;
        shift_next = shift_reg;
        done_next  = done_reg;
        sum_next   = sum_reg;
        gap_next   = gap_reg;
        off_a_next = off_a_reg;
        off_b_next = off_b_reg;
        sck        = 1'b0;
        valid      = 1'b0;
        value      = '0;
        if (cmd.finish)
        begin
            if (acmd_reg == CMD_CAL)
            begin
                valid      = 1'b1;
                value      = {1'b0, avg} - {1'b0, off_sel};
                phase_next = PH_IDLE;
            end
            else if (!ach_reg)
            begin
                // Channel A zeroed, move on to channel B, after a gap if gap_ticks is nonzero
                off_a_next = avg;
                ach_next   = 1'b1;
                done_next  = '0;
                sum_next   = '0;
                if (gap_ticks == '0)
                begin
                    phase_next = PH_WAIT;
                    gap_next   = '0;
                end
                else
                begin
                    phase_next = PH_GAP;
                    gap_next   = gap_ticks;
                end
            end
            else
            begin
                off_b_next = avg;
                phase_next = PH_IDLE;
            end
        end
        else if (cmd.accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (cmd_t'(command) != CMD_TICK)
                    begin
                        acmd_next  = cmd_t'(command);
                        ach_next   = (cmd_t'(command) == CMD_ZERO) ? 1'b0 : channel;
                        done_next  = '0;
                        sum_next   = '0;
                        pulse_next = '0;
                        shift_next = '0;
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (!dout)
                    begin
                        sck        = 1'b1;
                        pulse_next = '0;
                        shift_next = '0;
                        phase_next = PH_FALL;
                    end
                end
                PH_RISE:
                begin
                    sck        = 1'b1;
                    phase_next = PH_FALL;
                end
                PH_FALL:
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout};
                    if (pulse_inc >= PULSE_W'(DATA_BITS))
                    begin
                        pulse_next = '0;
                        phase_next = PH_XRISE;
                    end
                    else
                    begin
                        pulse_next = pulse_inc;
                        phase_next = PH_RISE;
                    end
                end
                PH_XRISE:
                begin
                    sck        = 1'b1;
                    phase_next = PH_XFALL;
                end
                PH_XFALL:
                begin
                    if (pulse_inc < PULSE_W'(EXTRA_PULSES))
                    begin
                        pulse_next = pulse_inc;
                        phase_next = PH_XRISE;
                    end
                    else if (acmd_reg == CMD_RAW)
                    begin
                        pulse_next = '0;
                        valid      = 1'b1;
                        value      = {1'b0, shift_reg};
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // Accumulate; hold the phase while the divider runs
                        pulse_next = '0;
                        sum_next   = sum_add;
                        done_next  = done_inc;
                        if (!need_div)
                        begin
                            if (gap_ticks == '0)
                            begin
                                phase_next = PH_WAIT;
                                gap_next   = '0;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                                gap_next   = gap_ticks;
                            end
                        end
                    end
                end
                PH_GAP:
                begin
                    if (gap_reg <= GAP_W'(1))
                    begin
                        gap_next   = '0;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        gap_next = gap_reg - GAP_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Load the output register once per finished tick
    assign load = (cmd.accept && !need_div) || cmd.finish;

    always_comb
    begin
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acmd_reg  <= CMD_TICK;
            ach_reg   <= 1'b0;
            pulse_reg <= '0;
            shift_reg <= '0;
            done_reg  <= '0;
            sum_reg   <= '0;
            gap_reg   <= '0;
            off_a_reg <= '0;
            off_b_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acmd_reg  <= acmd_next;
            ach_reg   <= ach_next;
            pulse_reg <= pulse_next;
            shift_reg <= shift_next;
            done_reg  <= done_next;
            sum_reg   <= sum_next;
            gap_reg   <= gap_next;
            off_a_reg <= off_a_next;
            off_b_reg <= off_b_next;
            ov_reg    <= ov_next;
        end
    end

    // Output payload, captured with the post-tick state
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sck_a_reg <= sck && !ach_next;
            sck_b_reg <= sck && ach_next;
            rv_reg    <= valid;
            val_reg   <= value;
            busy_reg  <= (phase_next != PH_IDLE);
            oa_reg    <= off_a_next;
            ob_reg    <= off_b_next;
        end
    end

    assign sts.need_div = need_div;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !ov_reg || !out_stall;

    assign out_valid    = ov_reg;
    assign sck_a        = sck_a_reg;
    assign sck_b        = sck_b_reg;
    assign result_valid = rv_reg;
    assign result_value = val_reg;
    assign busy_res     = busy_reg;
    assign offset_a_out = oa_reg;
    assign offset_b_out = ob_reg;

endmodule

`default_nettype wire

// ===== verif/reader_check.sv =====
`timescale 1ns / 1ps

module reader_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                dout_a,
    input  logic                                dout_b,
    input  logic [1:0]                          command,
    input  logic                                channel,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                sck_a,
    input  logic                                sck_b,
    input  logic                                result_valid,
    input  logic [badc_pkg::VAL_W-1:0]          result_value,
    input  logic                                busy_res,
    input  logic [badc_pkg::DATA_BITS-1:0]      offset_a_out,
    input  logic [badc_pkg::DATA_BITS-1:0]      offset_b_out,
    output int                                  fail_count,
    output int                                  pending
);
    import badc_pkg::*;

    typedef struct packed {
        logic                 sck_a;
        logic                 sck_b;
        logic                 rvalid;
        logic [VAL_W-1:0]     value;
        logic                 busy;
        logic [DATA_BITS-1:0] off_a;
        logic [DATA_BITS-1:0] off_b;
    } reading_t;

    // Readings expected on the result channel, oldest first
    reading_t reading_q[$];

    // Register copies
    logic [CNT_W-1:0] cfg_count;
    logic [GAP_W-1:0] cfg_gap;

    // Sequencer copy
    phase_t               ph;
    cmd_t                 act_cmd;
    logic                 act_ch;
    logic [PULSE_W-1:0]   pulses;
    logic [DATA_BITS-1:0] shreg;
    logic [CNT_W-1:0]     done_cnt;
    logic [SUM_W-1:0]     sum;
    logic [GAP_W-1:0]     gtimer;
    logic [DATA_BITS-1:0] off_a;
    logic [DATA_BITS-1:0] off_b;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // Wait between averaged conversions, or go straight to the next one
    function automatic void open_gap();
        if (cfg_gap == '0)
        begin
            ph = PH_WAIT;
            gtimer = '0;
        end
        else
        begin
            ph = PH_GAP;
            gtimer = cfg_gap;
        end
    endfunction

    // Advance the sequencer by one tick and return what it drives
    function automatic reading_t step_reader(input logic da, input logic db,
                                             input cmd_t cmd, input logic ch);
        reading_t             r;
        logic                 pin;
        logic                 sck;
        logic [CNT_W-1:0]     n;
        logic [DATA_BITS-1:0] avg;
        logic [DATA_BITS-1:0] tare;
        r = '0;
        sck = 1'b0;
        pin = act_ch ? db : da;
        case (ph)
            PH_IDLE:
            begin
                if (cmd != CMD_TICK)
                begin
                    act_cmd = cmd;
                    act_ch = (cmd == CMD_ZERO) ? 1'b0 : ch;
                    done_cnt = '0;
                    sum = '0;
                    pulses = '0;
                    shreg = '0;
                    ph = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (!pin)
                begin
                    sck = 1'b1;
                    pulses = '0;
                    shreg = '0;
                    ph = PH_FALL;
                end
            end
            PH_RISE:
            begin
                sck = 1'b1;
                ph = PH_FALL;
            end
            PH_FALL:
            begin
                shreg = {shreg[DATA_BITS-2:0], pin};
                pulses = pulses + PULSE_W'(1);
                if (pulses >= PULSE_W'(DATA_BITS))
                begin
                    pulses = '0;
                    ph = PH_XRISE;
                end
                else
                begin
                    ph = PH_RISE;
                end
            end
            PH_XRISE:
            begin
                sck = 1'b1;
                ph = PH_XFALL;
            end
            PH_XFALL:
            begin
                pulses = pulses + PULSE_W'(1);
                if (pulses < PULSE_W'(EXTRA_PULSES))
                begin
                    ph = PH_XRISE;
                end
                else
                begin
                    pulses = '0;
                    if (act_cmd == CMD_RAW)
                    begin
                        r.rvalid = 1'b1;
                        r.value = {1'b0, shreg};
                        ph = PH_IDLE;
                    end
                    else
                    begin
                        n = (cfg_count == '0) ? CNT_W'(1) : cfg_count;
                        sum = sum + SUM_W'(shreg);
                        done_cnt = done_cnt + CNT_W'(1);
                        if (done_cnt >= n)
                        begin
                            avg = DATA_BITS'(sum / SUM_W'(n));
                            if (act_cmd == CMD_CAL)
                            begin
                                tare = act_ch ? off_b : off_a;
                                r.rvalid = 1'b1;
                                r.value = {1'b0, avg} - {1'b0, tare};
                                ph = PH_IDLE;
                            end
                            else if (!act_ch)
                            begin
                                // channel A done: store it and move on to B
                                off_a = avg;
                                act_ch = 1'b1;
                                done_cnt = '0;
                                sum = '0;
                                open_gap();
                            end
                            else
                            begin
                                off_b = avg;
                                ph = PH_IDLE;
                            end
                        end
                        else
                        begin
                            open_gap();
                        end
                    end
                end
            end
            PH_GAP:
            begin
                if (gtimer <= GAP_W'(1))
                begin
                    gtimer = '0;
                    ph = PH_WAIT;
                end
                else
                begin
                    gtimer = gtimer - GAP_W'(1);
                end
            end
            default:
            begin
                ph = PH_IDLE;
            end
        endcase
        r.sck_a = !act_ch ? sck : 1'b0;
        r.sck_b = act_ch ? sck : 1'b0;
        r.busy = (ph != PH_IDLE);
        r.off_a = off_a;
        r.off_b = off_b;
        return r;
    endfunction

    task automatic log_miss(input string what, input logic [31:0] want,
                            input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
        end
    endtask

    task automatic cmp(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            log_miss(what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cfg_count = SAMPLE_COUNT_RST;
            cfg_gap = GAP_TICKS_RST;
            ph = PH_IDLE;
            act_cmd = CMD_TICK;
            act_ch = 1'b0;
            pulses = '0;
            shreg = '0;
            done_cnt = '0;
            sum = '0;
            gtimer = '0;
            off_a = '0;
            off_b = '0;
            reading_q.delete();
            pending = 0;
        end
        else
        begin
            // Track register writes, check read-back
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_SAMPLE_COUNT)
                    begin
                        cfg_count = pwdata[CNT_W-1:0];
                    end
                    else
                    begin
                        cfg_gap = pwdata[GAP_W-1:0];
                    end
                end
                else if (paddr[2] == REG_SAMPLE_COUNT)
                begin
                    cmp("sample_count read", 32'(cfg_count), 32'(prdata[CNT_W-1:0]));
                end
                else
                begin
                    cmp("gap_ticks read", 32'(cfg_gap), 32'(prdata[GAP_W-1:0]));
                end
            end

            // Compare the accepted result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (reading_q.size() == 0)
                begin
                    log_miss("result with none expected", 32'd0, 32'(result_value));
                end
                else
                begin
                    want = reading_q.pop_front();
                    cmp("sck_a", 32'(want.sck_a), 32'(sck_a));
                    cmp("sck_b", 32'(want.sck_b), 32'(sck_b));
                    cmp("result_valid", 32'(want.rvalid), 32'(result_valid));
                    cmp("result_value", 32'(want.value), 32'(result_value));
                    cmp("busy_res", 32'(want.busy), 32'(busy_res));
                    cmp("offset_a_out", 32'(want.off_a), 32'(offset_a_out));
                    cmp("offset_b_out", 32'(want.off_b), 32'(offset_b_out));
                end
            end

            // Predict the accepted request
            if (in_valid && !in_stall)
            begin
                reading_q.push_back(step_reader(dout_a, dout_b, cmd_t'(command), channel));
            end
            pending = reading_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import badc_pkg::*;

    typedef enum logic [1:0] {
        FILL_RANDOM = 2'd0,
        FILL_ONES   = 2'd1,
        FILL_ZEROS  = 2'd2
    } fill_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic                    dout_a;
    logic                    dout_b;
    logic [1:0]              command;
    logic                    channel;
    logic                    out_valid;
    logic                    out_stall;
    logic                    sck_a;
    logic                    sck_b;
    logic                    result_valid;
    logic signed [VAL_W-1:0] result_value;
    logic                    busy_res;
    logic [DATA_BITS-1:0]    offset_a_out;
    logic [DATA_BITS-1:0]    offset_b_out;

    int fail_count;
    int pending;

    // Register values as last written
    logic [CNT_W-1:0] cur_count;
    logic [GAP_W-1:0] cur_gap;

    int burst_left;
    int ticks_sent;
    bit squeeze_req;

    bridge_adc_reader_with_tare dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dout_a       (dout_a),
        .dout_b       (dout_b),
        .command      (command),
        .channel      (channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck_a        (sck_a),
        .sck_b        (sck_b),
        .result_valid (result_valid),
        .result_value (result_value),
        .busy_res     (busy_res),
        .offset_a_out (offset_a_out),
        .offset_b_out (offset_b_out)
    );

    reader_check check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dout_a       (dout_a),
        .dout_b       (dout_b),
        .command      (command),
        .channel      (channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck_a        (sck_a),
        .sck_b        (sck_b),
        .result_valid (result_valid),
        .result_value (result_value),
        .busy_res     (busy_res),
        .offset_a_out (offset_a_out),
        .offset_b_out (offset_b_out),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop
    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: stall on shifting patterns, with one long hold-off
    initial
    begin
        int mode;
        int span;
        bit squeezed;
        squeezed = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 128);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (squeeze_req && !squeezed)
                begin
                    squeezed = 1'b1;
                    out_stall <= 1'b1;
                    repeat (400) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ((k % 8) >= 5);
                endcase
            end
        end
    end

    // Offer one tick request and hold it until taken
    task automatic send_tick(input logic da, input logic db, input cmd_t cmd, input logic ch);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        dout_a <= da;
        dout_b <= db;
        command <= cmd;
        channel <= ch;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        burst_left--;
        ticks_sent++;
    endtask

    // Tick while busy; now and then carry a command that must be ignored
    task automatic busy_tick(input logic da, input logic db);
        cmd_t cmd;
        cmd = CMD_TICK;
        if ($urandom_range(0, 7) == 0)
        begin
            cmd = cmd_t'($urandom_range(1, 3));
        end
        send_tick(da, db, cmd, 1'($urandom_range(0, 1)));
    endtask

    task automatic pin_tick(input logic ch, input logic level);
        logic other;
        other = 1'($urandom_range(0, 1));
        if (ch)
        begin
            busy_tick(other, level);
        end
        else
        begin
            busy_tick(level, other);
        end
    endtask

    // One conversion: wait with the pin high, pull it low, then clock out the word and the extra pulses
    task automatic send_conversion(input logic ch, input fill_t fill);
        int waits;
        logic data_bit;
        waits = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
        repeat (waits) pin_tick(ch, 1'b1);
        pin_tick(ch, 1'b0);
        for (int k = 0; k < 2 * DATA_BITS - 1; k++)
        begin
            case (fill)
                FILL_ONES: data_bit = 1'b1;
                FILL_ZEROS: data_bit = 1'b0;
                default: data_bit = 1'($urandom_range(0, 1));
            endcase
            // even ticks are the falling edges that sample the pin
            pin_tick(ch, ((k % 2) == 0) ? data_bit : 1'($urandom_range(0, 1)));
        end
        repeat (2 * EXTRA_PULSES) pin_tick(ch, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_gap();
        repeat (cur_gap) busy_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic average_channel(input logic ch, input fill_t fill);
        int n;
        n = (cur_count == '0) ? 1 : int'(cur_count);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                send_gap();
            end
            send_conversion(ch, fill);
        end
    endtask

    // Issue a command from idle and feed ticks until the reader is idle again
    task automatic run_measure(input cmd_t cmd, input logic ch, input fill_t fill);
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cmd, ch);
        case (cmd)
            CMD_RAW:
            begin
                send_conversion(ch, fill);
            end
            CMD_CAL:
            begin
                average_channel(ch, fill);
            end
            CMD_ZERO:
            begin
                average_channel(1'b0, fill);
                send_gap();
                average_channel(1'b1, fill);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drain all outstanding results
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic sel, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram both registers from idle; upper bus bits sometimes carry junk
    task automatic set_reader(input logic [CNT_W-1:0] count, input logic [GAP_W-1:0] gap);
        wait_idle();
        apb_access(1'b1, REG_SAMPLE_COUNT, {$urandom_range(0, 1) ? 24'($urandom()) : 24'd0, count});
        apb_access(1'b1, REG_GAP_TICKS, {$urandom_range(0, 1) ? 16'($urandom()) : 16'd0, gap});
        apb_access(1'b0, REG_SAMPLE_COUNT, 32'd0);
        apb_access(1'b0, REG_GAP_TICKS, 32'd0);
        cur_count = count;
        cur_gap = gap;
    endtask

    initial
    begin
        int pick;
        logic [CNT_W-1:0] count;
        logic [GAP_W-1:0] gap;
        cmd_t cmd;
        fill_t fill;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        dout_a <= 1'b1;
        dout_b <= 1'b1;
        command <= CMD_TICK;
        channel <= 1'b0;
        burst_left = 0;
        ticks_sent = 0;
        squeeze_req = 1'b0;
        cur_count = SAMPLE_COUNT_RST;
        cur_gap = GAP_TICKS_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, tick-only requests and raw reads at full scale, zero scale and with random data
        apb_access(1'b0, REG_SAMPLE_COUNT, 32'd0);
        apb_access(1'b0, REG_GAP_TICKS, 32'd0);
        repeat (3) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), CMD_TICK,
                             1'($urandom_range(0, 1)));
        run_measure(CMD_RAW, 1'b0, FILL_ONES);
        run_measure(CMD_RAW, 1'b1, FILL_ZEROS);
        run_measure(CMD_RAW, 1'b1, FILL_RANDOM);

        // Tare at full scale, then read zero scale: most negative result
        set_reader(8'd1, 16'd0);
        run_measure(CMD_CAL, 1'b0, FILL_ONES);
        run_measure(CMD_ZERO, 1'b1, FILL_ONES);
        run_measure(CMD_CAL, 1'b1, FILL_ZEROS);
        run_measure(CMD_CAL, 1'b0, FILL_ONES);

        // Sample count of zero acts as one
        set_reader(8'd0, 16'd1);
        run_measure(CMD_ZERO, 1'b0, FILL_RANDOM);
        run_measure(CMD_CAL, 1'b1, FILL_RANDOM);

        // Full-scale words averaged over three conversions
        set_reader(8'd3, 16'd0);
        run_measure(CMD_CAL, 1'b0, FILL_ONES);

        // Long gap between the A and B halves of a zeroing
        set_reader(8'd1, 16'd200);
        run_measure(CMD_ZERO, 1'b1, FILL_RANDOM);

        // Random phases of settings and commands
        while (ticks_sent < 2000)
        begin
            pick = $urandom_range(0, 19);
            count = (pick < 3) ? 8'd0 : (pick < 17) ? 8'($urandom_range(1, 4))
                                                     : 8'($urandom_range(5, 16));
            pick = $urandom_range(0, 9);
            gap = (pick < 5) ? 16'd0 : (pick < 9) ? 16'($urandom_range(1, 8))
                                                   : 16'($urandom_range(9, 60));
            set_reader(count, gap);
            // Long hold-off on the result side while requests keep coming
            squeeze_req = 1'b1;
            repeat ($urandom_range(3, 8))
            begin
                repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)),
                                                        1'($urandom_range(0, 1)), CMD_TICK,
                                                        1'($urandom_range(0, 1)));
                pick = $urandom_range(0, 9);
                cmd = (pick < 4) ? CMD_RAW : (pick < 8) ? CMD_CAL : CMD_ZERO;
                pick = $urandom_range(0, 9);
                fill = (pick < 8) ? FILL_RANDOM : (pick == 8) ? FILL_ONES : FILL_ZEROS;
                run_measure(cmd, 1'($urandom_range(0, 1)), fill);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/badc_pkg.sv
rtl/core/badc_div.sv
rtl/core/badc_ctrl.sv
rtl/core/badc_dp.sv
rtl/core/bridge_adc_reader_with_tare.sv
verif/reader_check.sv
verif/tb.sv
